FILE: rtl/obse_pkg.sv
// Package for the offset bitmap set engine.
// Holds action codes, register indexes, stream widths and the command and
// status records passed between the controller and the datapath.
`default_nettype none
package obse_pkg;

	localparam int ACTION_W    = 2;
	localparam int ELEM_W      = 32;
	localparam int COUNT_W     = 13;
	localparam int LEN_REG_W   = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;

	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_LENGTH = 1'd1;

	typedef struct packed {
		logic load;
		logic decode;
		logic clear;
		logic add;
		logic probe;
		logic first;
		logic hit;
		logic miss;
		logic advance;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic                oor;
		logic                word_hit;
		logic                cand_ok;
		logic                last_word;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/obse_ctrl.sv
// Controller state machine of the offset bitmap set engine.
// Depends on obse_pkg; drives the datapath through obse_pkg::cmd_t.
`default_nettype none
module obse_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire obse_pkg::sts_t sts,
	output obse_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_EXAM   = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.act == obse_pkg::ACT_CLEAR) begin
					cmd.clear = 1'b1;
					state_d   = ST_DONE;
				end else if ((sts.act != obse_pkg::ACT_ADD && sts.act != obse_pkg::ACT_QUERY)
						|| sts.oor) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EXAM;
				end
			end
			ST_EXAM, ST_SCAN: begin
				if (state_q == ST_EXAM && sts.act == obse_pkg::ACT_ADD) begin
					cmd.add = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.probe = 1'b1;
					cmd.first = (state_q == ST_EXAM);
					if (sts.word_hit) begin
						cmd.hit  = sts.cand_ok;
						cmd.miss = !sts.cand_ok;
						state_d  = ST_DONE;
					end else if (sts.last_word) begin
						cmd.miss = 1'b1;
						state_d  = ST_DONE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_SCAN;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/obse_dpath.sv
// Datapath of the offset bitmap set engine: registers, bitmap memory with
// word valid bits, member count, next-member search and result register.
// Depends on obse_pkg; controlled by obse_ctrl.
`default_nettype none
module obse_dpath #(
	parameter int WORD_BITS = 64,
	parameter int CAPACITY  = 4096
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [obse_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [obse_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic [obse_pkg::IN_TDATA_W-1:0]       in_data,
	output logic      [obse_pkg::OUT_TDATA_W-1:0]      out_data,
	input  wire obse_pkg::cmd_t                        cmd,
	output obse_pkg::sts_t                             sts
);

	localparam int LOG_WB    = $clog2(WORD_BITS);
	localparam int WB        = 1 << LOG_WB;
	localparam int NUM_WORDS = (CAPACITY + WB - 1) / WB;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IW        = AW + LOG_WB;
	localparam int CW        = IW + 1;
	localparam int LEN_W     = $clog2(CAPACITY + 1);
	localparam int POP_W     = $clog2(CAPACITY + 1);
	localparam int EW        = obse_pkg::ELEM_W;

	function automatic logic [LOG_WB-1:0] first_set(input logic [WB-1:0] w);
		logic [LOG_WB-1:0] r;
		r = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = LOG_WB'(i);
			end
		end
		return r;
	endfunction

	logic [EW-1:0]                 base_value_q;
	logic [obse_pkg::LEN_REG_W-1:0] set_length_q;

	logic [obse_pkg::ACTION_W-1:0] action_q;
	logic [EW-1:0]                 element_q;
	logic [IW-1:0]                 idx_q;
	logic [LEN_W-1:0]              len_q;
	logic                          oor_q;
	logic [AW-1:0]                 wptr_q;
	logic [POP_W-1:0]              pop_q;

	logic [WB-1:0]                 mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0]          wvalid_q;
	logic [WB-1:0]                 rd_word_q;
	logic                          rd_valid_q;

	logic                          r_new_q;
	logic                          r_member_q;
	logic [EW-1:0]                 r_next_q;
	logic                          r_found_q;

	logic                          o_new_q;
	logic                          o_member_q;
	logic [EW-1:0]                 o_next_q;
	logic                          o_found_q;
	logic [obse_pkg::COUNT_W-1:0]  o_count_q;
	logic                          o_oor_q;

	logic [EW-1:0]                 idx_calc;
	logic [LEN_W-1:0]              len_calc;
	logic                          oor_calc;
	logic [WB-1:0]                 word_eff;
	logic [WB-1:0]                 above_mask;
	logic [WB-1:0]                 word_probe;
	logic                          elem_bit;
	logic [IW-1:0]                 pos;
	logic [CW-1:0]                 next_start;
	logic [AW-1:0]                 next_wptr;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;

	assign len_calc = (32'(set_length_q) > 32'(CAPACITY)) ? LEN_W'(CAPACITY)
			: LEN_W'(set_length_q);
	assign idx_calc = element_q - base_value_q;
	assign oor_calc = idx_calc >= 32'(len_calc);

	assign word_eff   = rd_valid_q ? rd_word_q : '0;
	assign above_mask = ({WB{1'b1}} << idx_q[LOG_WB-1:0]) << 1;
	assign word_probe = cmd.first ? (word_eff & above_mask) : word_eff;
	assign elem_bit   = word_eff[idx_q[LOG_WB-1:0]];
	assign pos        = {wptr_q, first_set(word_probe)};
	assign next_start = {(AW + 1)'({1'b0, wptr_q}) + (AW + 1)'(1), LOG_WB'(0)};
	assign next_wptr  = wptr_q + AW'(1);

	assign rd_en   = cmd.decode || cmd.advance;
	assign rd_addr = cmd.decode ? idx_calc[LOG_WB +: AW] : next_wptr;
	assign wr_en   = cmd.add && !elem_bit;

	assign sts.act       = action_q;
	assign sts.oor       = oor_calc;
	assign sts.word_hit  = |word_probe;
	assign sts.cand_ok   = CW'(pos) < CW'(len_q);
	assign sts.last_word = next_start >= CW'(len_q);

	assign out_data = {(obse_pkg::OUT_TDATA_W - 49)'(0), o_oor_q, o_count_q, o_found_q,
			o_next_q, o_member_q, o_new_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= word_eff | (WB'(1) << idx_q[LOG_WB-1:0]);
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_value_q <= '0;
			set_length_q <= '0;
			wvalid_q     <= '0;
			rd_valid_q   <= 1'b0;
			pop_q        <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == obse_pkg::REG_BASE_VALUE) begin
					base_value_q <= cfg_data;
				end else if (cfg_index == obse_pkg::REG_SET_LENGTH) begin
					set_length_q <= cfg_data[obse_pkg::LEN_REG_W-1:0];
				end
			end
			if (rd_en) begin
				rd_valid_q <= wvalid_q[rd_addr];
			end
			if (cmd.clear) begin
				wvalid_q <= '0;
				pop_q    <= '0;
			end else if (wr_en) begin
				wvalid_q[wptr_q] <= 1'b1;
				pop_q            <= pop_q + POP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= in_data[obse_pkg::ACTION_W-1:0];
			element_q <= in_data[obse_pkg::ACTION_W +: EW];
		end
		if (cmd.decode) begin
			idx_q      <= idx_calc[IW-1:0];
			len_q      <= len_calc;
			oor_q      <= oor_calc && (action_q == obse_pkg::ACT_ADD
					|| action_q == obse_pkg::ACT_QUERY);
			wptr_q     <= idx_calc[LOG_WB +: AW];
			r_new_q    <= 1'b0;
			r_member_q <= 1'b0;
			r_next_q   <= '0;
			r_found_q  <= 1'b0;
		end else if (cmd.advance) begin
			wptr_q <= next_wptr;
		end
		if (cmd.add) begin
			r_member_q <= elem_bit;
			r_new_q    <= !elem_bit;
		end
		if (cmd.probe && cmd.first) begin
			r_member_q <= elem_bit;
		end
		if (cmd.hit) begin
			r_next_q  <= base_value_q + EW'(pos);
			r_found_q <= 1'b1;
		end else if (cmd.miss) begin
			r_next_q  <= base_value_q + EW'(len_q);
			r_found_q <= 1'b0;
		end
		if (cmd.out_load) begin
			o_new_q    <= r_new_q;
			o_member_q <= r_member_q;
			o_next_q   <= r_next_q;
			o_found_q  <= r_found_q;
			o_count_q  <= obse_pkg::COUNT_W'(pop_q);
			o_oor_q    <= oor_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/offset_bitmap_set_engine.sv
// Offset bitmap set engine: one request at a time, result in an output register.
// Every request passes the idle, decode and done states; in-range add and query also pass the
// examine state, and a query enters the scan state for each further bitmap word read.
// The next request is taken in the cycle after the result is loaded, while that result
// may still wait. The single-port bitmap memory read sets the pace. Asynchronous reset
// clears control, config registers, count and word valid bits: the bitmap reads empty.
`default_nettype none
module offset_bitmap_set_engine #(
	parameter int WORD_BITS = 64,
	parameter int CAPACITY  = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// Fields from bit 0: action[1:0], element[33:2], zero pad.
	input  wire logic [obse_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// Fields from bit 0: was_new[0], is_member[1], next_member[33:2],
	// next_found[34], member_count[47:35], out_of_range[48], zero pad.
	output logic      [obse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [obse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [obse_pkg::CFG_DATA_W-1:0]    cfg_data
);

	obse_pkg::cmd_t cmd;
	obse_pkg::sts_t sts;

	obse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	obse_dpath #(
		.WORD_BITS (WORD_BITS),
		.CAPACITY  (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in progress");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_axis_tvalid)
		else $error("loaded result not presented");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.add, cmd.hit, cmd.miss, cmd.advance}))
		else $error("conflicting datapath commands");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit |-> (sts.word_hit && sts.cand_ok))
		else $error("next member reported beyond the range");

endmodule
`default_nettype wire

FILE: bench/offset_bitmap_set_engine_tb.sv
// Self-checking bench for offset_bitmap_set_engine: drives clear, add, query and
// undefined-action requests over several base and length settings and checks every
// result against its own bitmap predictor. Depends on obse_pkg and the engine RTL.
`timescale 1ns / 100ps
module offset_bitmap_set_engine_tb;

	localparam int CAP = 4096;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int CONFIG_PAUSE = 8;
	localparam logic [obse_pkg::ACTION_W-1:0] ACT_NOP = 2'd3;

	typedef struct packed {
		logic [obse_pkg::ACTION_W-1:0] action;
		logic [obse_pkg::ELEM_W-1:0]   element;
	} set_request_t;

	typedef struct packed {
		logic                         was_new;
		logic                         is_member;
		logic [obse_pkg::ELEM_W-1:0]  next_member;
		logic                         next_found;
		logic [obse_pkg::COUNT_W-1:0] member_count;
		logic                         out_of_range;
	} set_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [obse_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [obse_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             cfg_we = 1'b0;
	logic [obse_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [obse_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	bit                               member_bits [CAP];
	int unsigned                      member_total = 0;
	logic [obse_pkg::ELEM_W-1:0]      model_base = '0;
	logic [obse_pkg::LEN_REG_W-1:0]   model_len = '0;

	set_request_t           request_q [$];
	set_result_t            expected_q [$];
	set_request_t           in_flight;
	set_request_t           next_req;
	set_result_t            due_result;
	int                     burst_left = 0;
	int                     gap_left = 0;
	int                     ready_phase = 0;
	logic [1:0]             stall_mode = 2'd0;
	int                     idle_cycles = 0;
	int                     mismatches = 0;

	offset_bitmap_set_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned active_span();
		return (model_len > CAP) ? CAP : int'(model_len);
	endfunction

	function automatic set_result_t apply_request(set_request_t req);
		set_result_t res;
		int unsigned span;
		int unsigned pos;
		int unsigned i;
		res = '0;
		span = active_span();
		pos = req.element - model_base;
		case (req.action)
			obse_pkg::ACT_CLEAR: begin
				member_bits = '{default: 0};
				member_total = 0;
			end
			obse_pkg::ACT_ADD: begin
				if (pos >= span) begin
					res.out_of_range = 1'b1;
				end else begin
					res.is_member = member_bits[pos];
					if (!member_bits[pos]) begin
						member_bits[pos] = 1'b1;
						member_total++;
						res.was_new = 1'b1;
					end
				end
			end
			obse_pkg::ACT_QUERY: begin
				if (pos >= span) begin
					res.out_of_range = 1'b1;
				end else begin
					res.is_member = member_bits[pos];
					res.next_member = model_base + span;
					for (i = pos + 1; i < span && !res.next_found; i++) begin
						if (member_bits[i]) begin
							res.next_member = model_base + i;
							res.next_found = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		res.member_count = obse_pkg::COUNT_W'(member_total);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_request(input logic [obse_pkg::ACTION_W-1:0] action,
			input logic [obse_pkg::ELEM_W-1:0] element);
		set_request_t req;
		req.action = action;
		req.element = element;
		request_q.push_back(req);
	endtask

	task automatic write_config(input logic [obse_pkg::ELEM_W-1:0] base,
			input logic [obse_pkg::LEN_REG_W-1:0] len);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= obse_pkg::REG_BASE_VALUE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= obse_pkg::REG_SET_LENGTH;
		cfg_data <= obse_pkg::CFG_DATA_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		model_base = base;
		model_len = len;
	endtask

	task automatic settle(input int pause);
		while (request_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
			@(negedge clk);
		repeat (pause) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(apply_request(in_flight));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (request_q.size() != 0) begin
					next_req = request_q.pop_front();
					in_flight <= next_req;
					s_axis_tdata <= {{(obse_pkg::IN_TDATA_W - obse_pkg::ELEM_W
						- obse_pkg::ACTION_W){1'b0}},
						next_req.element, next_req.action};
					s_axis_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (ready_phase == 0) begin
				stall_mode <= 2'($urandom_range(0, 3));
				ready_phase <= $urandom_range(20, 200);
			end else begin
				ready_phase <= ready_phase - 1;
			end
			case (stall_mode)
				2'd0: m_axis_tready <= 1'b1;
				2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
				2'd2: m_axis_tready <= (ready_phase % 4) == 0;
				default: m_axis_tready <= (ready_phase % 32) >= 20;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request pending: tdata %0h", m_axis_tdata);
					mismatches++;
				end else begin
					due_result = expected_q.pop_front();
					check_field("was_new", 32'(due_result.was_new), 32'(m_axis_tdata[0]));
					check_field("is_member", 32'(due_result.is_member),
						32'(m_axis_tdata[1]));
					check_field("next_member", due_result.next_member,
						m_axis_tdata[obse_pkg::ELEM_W+1:2]);
					check_field("next_found", 32'(due_result.next_found),
						32'(m_axis_tdata[obse_pkg::ELEM_W+2]));
					check_field("member_count", 32'(due_result.member_count),
						32'(m_axis_tdata[obse_pkg::ELEM_W+obse_pkg::COUNT_W+2:
						obse_pkg::ELEM_W+3]));
					check_field("out_of_range", 32'(due_result.out_of_range),
						32'(m_axis_tdata[obse_pkg::ELEM_W+obse_pkg::COUNT_W+3]));
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| cfg_we) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [obse_pkg::ELEM_W-1:0]    phase_base [9];
		logic [obse_pkg::LEN_REG_W-1:0] phase_len [9];
		int                             phase_items [9];
		int unsigned                    span;
		int unsigned                    pos;
		int unsigned                    hotspot;
		int                             roll;
		logic [obse_pkg::ACTION_W-1:0]  action;
		logic [obse_pkg::ELEM_W-1:0]    element;

		phase_base = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom, 32'h8000_0000,
			$urandom, 32'hFFFF_F800, $urandom, 32'hFFFF_FFC0};
		phase_len = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd100,
			13'($urandom_range(2, 4095)), 13'd4096, 13'd64, 13'd65};
		phase_items = '{300, 60, 40, 300, 250, 250, 300, 200, 230};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_config(32'hFFFF_FF00, 13'd4096);
		@(negedge clk);
		queue_request(obse_pkg::ACT_QUERY, 32'hFFFF_FF00);
		queue_request(obse_pkg::ACT_ADD, 32'hFFFF_FF00);
		queue_request(obse_pkg::ACT_ADD, 32'hFFFF_FF00);
		queue_request(obse_pkg::ACT_ADD, 32'hFFFF_FFFF);
		queue_request(obse_pkg::ACT_ADD, 32'h0000_0000);
		queue_request(obse_pkg::ACT_ADD, 32'h0000_0EFF);
		queue_request(obse_pkg::ACT_QUERY, 32'hFFFF_FF00);
		queue_request(obse_pkg::ACT_QUERY, 32'hFFFF_FFFF);
		queue_request(obse_pkg::ACT_QUERY, 32'h0000_0000);
		queue_request(obse_pkg::ACT_QUERY, 32'h0000_0EFF);
		queue_request(obse_pkg::ACT_ADD, 32'h0000_0F00);
		queue_request(obse_pkg::ACT_QUERY, 32'hFFFF_FEFF);
		queue_request(ACT_NOP, 32'hAAAA_AAAA);
		queue_request(ACT_NOP, 32'h5555_5555);
		queue_request(obse_pkg::ACT_ADD, 32'h0000_003F);
		queue_request(obse_pkg::ACT_QUERY, 32'h0000_003E);
		queue_request(obse_pkg::ACT_ADD, 32'h7FFF_FFFF);
		queue_request(obse_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
		queue_request(obse_pkg::ACT_QUERY, 32'h0000_0000);
		queue_request(obse_pkg::ACT_ADD, 32'h0000_0001);
		queue_request(obse_pkg::ACT_QUERY, 32'hFFFF_FF00);
		settle(CONFIG_PAUSE);

		for (int p = 0; p < 9; p++) begin
			write_config(phase_base[p], phase_len[p]);
			@(negedge clk);
			span = active_span();
			hotspot = (span == 0) ? 0 : $urandom_range(0, span - 1);
			if ($urandom_range(0, 1) == 0)
				queue_request(obse_pkg::ACT_CLEAR, $urandom);
			for (int n = 0; n < phase_items[p]; n++) begin
				roll = $urandom_range(0, 99);
				element = $urandom;
				if (roll < 3) begin
					action = obse_pkg::ACT_CLEAR;
				end else if (roll < 5) begin
					action = ACT_NOP;
				end else begin
					action = (roll < 50) ? obse_pkg::ACT_ADD : obse_pkg::ACT_QUERY;
					roll = $urandom_range(0, 9);
					if (span == 0 || roll == 0) begin
						case ($urandom_range(0, 2))
							0: element = model_base + span;
							1: element = model_base + span + $urandom_range(0, 5000);
							default: ;
						endcase
					end else begin
						if (roll < 4) begin
							pos = (hotspot + $urandom_range(0, 63)) % span;
						end else if (roll < 5) begin
							pos = span - 1 - $urandom_range(0, (span > 8) ? 8 : span - 1);
						end else begin
							pos = $urandom_range(0, span - 1);
						end
						element = model_base + pos;
						if ($urandom_range(0, 31) == 0)
							hotspot = $urandom_range(0, span - 1);
					end
				end
				queue_request(action, element);
			end
			settle(CONFIG_PAUSE);
		end

		settle(DRAIN_CYCLES);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
